/* sv/nak_pdu_stream_decoder_unit_assert.svh */
// Assertion macros for the checker file.
`ifndef NAK_PDU_STREAM_DECODER_UNIT_ASSERT_SVH
`define NAK_PDU_STREAM_DECODER_UNIT_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define NPSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define NPSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/npsd_pkg.sv */
`default_nettype none

package npsd_pkg;

	// Most gap pairs kept in one PDU
	localparam int MAX_GAPS = 16;
	localparam int GAP_CNT_W = $clog2(MAX_GAPS + 1);

	localparam logic [7:0]  NAK_DIRECTIVE = 8'h08;
	localparam logic [15:0] HEADER_BYTES  = 16'd9;
	localparam logic [15:0] GAP_BYTES     = 16'd8;
	localparam logic [15:0] COUNTER_MAX   = 16'hFFFF;

	// Result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int OUT_TDATA_W = 88;

	typedef enum logic [1:0] {
		KIND_SCOPE   = 2'd0,
		KIND_GAP     = 2'd1,
		KIND_SUMMARY = 2'd2
	} record_kind_t;

	typedef struct packed {
		record_kind_t record_kind;
		logic [31:0]  start_offset;
		logic [31:0]  end_offset;
		logic [3:0]   gap_index;
		logic [4:0]   gaps_found;
		logic [7:0]   bytes_consumed;
		logic         status;
		logic         last_of_run;
	} rec_t;

	// Records produced by one accepted byte: an optional scope/gap record,
	// then an optional summary record.
	typedef struct packed {
		logic pair_v;
		rec_t pair;
		logic sum_v;
		rec_t sum;
	} push_t;

endpackage

`default_nettype wire

/* sv/npsd_parse.sv */
`default_nettype none

module npsd_parse
	import npsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_pdu,
	output push_t           push
);

	logic [15:0]          cnt_q;
	logic [63:0]          word_q;
	logic                 dir_ok_q;
	logic [GAP_CNT_W-1:0] kept_q;

	logic [15:0]          cnt_nxt;
	logic [63:0]          word_nxt;
	logic                 dir_nxt;
	logic [GAP_CNT_W-1:0] kept_nxt;
	logic                 proc_ok;
	logic                 scope_hit;
	logic                 gap_hit;
	logic                 sum_ok;
	logic [15:0]          pos_rel;
	logic [15:0]          bytes_full;

	// Per-byte decode against the current position
	always_comb begin
		word_nxt  = {word_q[55:0], data_byte};
		dir_nxt   = (cnt_q == 16'd0) ? (data_byte == NAK_DIRECTIVE) : dir_ok_q;
		proc_ok   = dir_nxt && (cnt_q != COUNTER_MAX);
		pos_rel   = cnt_q - HEADER_BYTES;
		scope_hit = proc_ok && (cnt_q == HEADER_BYTES - 16'd1);
		gap_hit   = proc_ok && (cnt_q >= HEADER_BYTES)
			&& ((pos_rel & (GAP_BYTES - 16'd1)) == (GAP_BYTES - 16'd1))
			&& (kept_q < GAP_CNT_W'(MAX_GAPS));
		kept_nxt  = kept_q + GAP_CNT_W'(gap_hit);
		cnt_nxt   = (cnt_q == COUNTER_MAX) ? cnt_q : cnt_q + 16'd1;
		// Valid when the directive matched and the header is complete
		sum_ok    = dir_nxt && (cnt_nxt >= HEADER_BYTES);
		bytes_full = HEADER_BYTES + (16'(kept_nxt) << 3);
	end

	// Build the records for this byte
	always_comb begin
		push.pair_v                   = accept && (scope_hit || gap_hit);
		push.pair.record_kind         = scope_hit ? KIND_SCOPE : KIND_GAP;
		push.pair.start_offset        = word_nxt[63:32];
		push.pair.end_offset          = word_nxt[31:0];
		push.pair.gap_index           = scope_hit ? 4'd0 : 4'(kept_q);
		push.pair.gaps_found          = 5'd0;
		push.pair.bytes_consumed      = 8'd0;
		push.pair.status              = 1'b0;
		push.pair.last_of_run         = !end_of_pdu;

		push.sum_v                    = accept && end_of_pdu;
		push.sum.record_kind          = KIND_SUMMARY;
		push.sum.start_offset         = 32'd0;
		push.sum.end_offset           = 32'd0;
		push.sum.gap_index            = 4'd0;
		push.sum.gaps_found           = sum_ok ? 5'(kept_nxt) : 5'd0;
		push.sum.bytes_consumed       = sum_ok ? bytes_full[7:0] : 8'd0;
		push.sum.status               = !sum_ok;
		push.sum.last_of_run          = 1'b1;
	end

	// Parser state; end of PDU returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			word_q   <= '0;
			dir_ok_q <= 1'b0;
			kept_q   <= '0;
		end else if (accept) begin
			if (end_of_pdu) begin
				cnt_q    <= '0;
				word_q   <= '0;
				dir_ok_q <= 1'b0;
				kept_q   <= '0;
			end else begin
				cnt_q    <= cnt_nxt;
				word_q   <= word_nxt;
				dir_ok_q <= dir_nxt;
				kept_q   <= kept_nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/npsd_out_queue.sv */
`default_nettype none

module npsd_out_queue
	import npsd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output rec_t       out_rec
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QPTR_W-1:0] sum_addr;
	logic [QCNT_W-1:0] n_push;

	// Room for the two records a single byte can cause
	assign room      = cnt_q <= QCNT_W'(QDEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_rec   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign sum_addr  = wr_q + QPTR_W'(push.pair_v);
	assign n_push    = QCNT_W'(push.pair_v) + QCNT_W'(push.sum_v);

	// Record storage
	always_ff @(posedge clk) begin
		if (push.pair_v) begin
			mem_q[wr_q] <= push.pair;
		end
		if (push.sum_v) begin
			mem_q[sum_addr] <= push.sum;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + n_push - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

/* sv/nak_pdu_stream_decoder_unit.sv */
// Channel   Dir  Width  Contents
// s_axis    in   8+1    tdata: data_byte; tlast: end_of_pdu
// m_axis    out  88+2+1 tdata: offsets, counts, status; tuser: record_kind;
//                       tlast: last_of_run
//
// One byte is accepted per cycle while s_axis_tready is high; its records
// are written to a four-entry result queue in the same cycle and shown on
// m_axis once older records have gone. A byte that causes a gap or scope
// record plus a summary yields two records; s_axis_tready drops only while
// the queue has less than two free entries, set by downstream back-pressure.
// arst_n clears the parser state and empties the queue.
`default_nettype none

module nak_pdu_stream_decoder_unit
	import npsd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,  // [7:0] data_byte
	input  wire logic                   s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [31:0] start_offset, [63:32] end_offset, [67:64] gap_index,
	// [72:68] gaps_found, [80:73] bytes_consumed, [81] status, [87:82] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [1:0]                  m_axis_tuser,  // [1:0] record_kind
	output logic                        m_axis_tlast
);

	logic  accept;
	push_t push;
	rec_t  rec;

	assign accept = s_axis_tvalid && s_axis_tready;

	npsd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (s_axis_tdata),
		.end_of_pdu (s_axis_tlast),
		.push       (push)
	);

	npsd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (rec)
	);

	// Output packing
	assign m_axis_tdata = {6'd0, rec.status, rec.bytes_consumed, rec.gaps_found,
		rec.gap_index, rec.end_offset, rec.start_offset};
	assign m_axis_tuser = rec.record_kind;
	assign m_axis_tlast = rec.last_of_run;

endmodule

`default_nettype wire

/* sv/npsd_checker.sv */
`default_nettype none
`include "nak_pdu_stream_decoder_unit_assert.svh"

module npsd_checker
	import npsd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [1:0]             m_axis_tuser,
	input wire logic                   m_axis_tlast
);

	// A stalled result stays offered
	`NPSD_ASSERT(a_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

	// A summary always closes the run of its byte
	`NPSD_ASSERT_ALWAYS(a_sum_last, clk, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |-> m_axis_tlast, "summary without tlast")

	// Invalid status only in a summary with zero counts
	`NPSD_ASSERT(a_bad_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[81] |-> (m_axis_tuser == KIND_SUMMARY) && (m_axis_tdata[80:68] == 13'd0), "invalid record carries counts")

endmodule

bind nak_pdu_stream_decoder_unit npsd_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/tb_nak_pdu_stream_decoder_unit.sv */
`timescale 1ns / 100ps

module tb_nak_pdu_stream_decoder_unit;
	import npsd_pkg::*;

	// One decoded record, unpacked from the master side
	typedef struct {
		record_kind_t kind;
		logic [31:0]  start_off;
		logic [31:0]  end_off;
		logic [3:0]   gap_idx;
		logic [4:0]   gaps;
		logic [7:0]   consumed;
		logic         status;
		logic         last;
	} nak_rec_t;

	typedef logic [7:0] pdu_bytes_t[$];

	// Tracks the decoder's parse state and the records still owed by the block
	class nak_decode_board;
		logic [15:0]  byte_count;
		logic [63:0]  shift_word;
		bit           dir_ok;
		int unsigned  gaps_kept;
		nak_rec_t     pending[$];
		int           errors;

		function new();
			clear_pdu();
			errors = 0;
		endfunction

		function void clear_pdu();
			byte_count = '0;
			shift_word = '0;
			dir_ok     = 1'b0;
			gaps_kept  = 0;
		endfunction

		function nak_rec_t make_rec(record_kind_t k, logic [31:0] s, logic [31:0] e,
				logic [3:0] gi, logic [4:0] gf, logic [7:0] bc, logic st);
			nak_rec_t r;
			r.kind = k; r.start_off = s; r.end_off = e; r.gap_idx = gi;
			r.gaps = gf; r.consumed = bc; r.status = st; r.last = 1'b0;
			return r;
		endfunction

		// Accepted input byte: work out the records it causes
		function void note_byte(logic [7:0] b, logic eop);
			logic [15:0] pos;
			int          n;
			bit          good;
			pos = byte_count;
			n = 0;
			shift_word = {shift_word[55:0], b};
			if (pos == 16'd0)
				dir_ok = (b == NAK_DIRECTIVE);
			if (dir_ok && pos < COUNTER_MAX) begin
				if (pos == HEADER_BYTES - 16'd1) begin
					pending.push_back(make_rec(KIND_SCOPE, shift_word[63:32], shift_word[31:0],
						4'd0, 5'd0, 8'd0, 1'b0));
					n++;
				end else if (pos >= HEADER_BYTES &&
						((pos - HEADER_BYTES) % GAP_BYTES) == GAP_BYTES - 16'd1) begin
					if (gaps_kept < MAX_GAPS) begin
						pending.push_back(make_rec(KIND_GAP, shift_word[63:32], shift_word[31:0],
							gaps_kept[3:0], 5'd0, 8'd0, 1'b0));
						n++;
						gaps_kept++;
					end
				end
			end
			if (byte_count < COUNTER_MAX)
				byte_count++;
			if (eop) begin
				good = dir_ok && byte_count >= HEADER_BYTES;
				if (good)
					pending.push_back(make_rec(KIND_SUMMARY, '0, '0, 4'd0, gaps_kept[4:0],
						8'(HEADER_BYTES + GAP_BYTES * gaps_kept), 1'b0));
				else
					pending.push_back(make_rec(KIND_SUMMARY, '0, '0, 4'd0, 5'd0, 8'd0, 1'b1));
				n++;
				clear_pdu();
			end
			if (n > 0)
				pending[$].last = 1'b1;
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// Accepted output record: compare with the oldest one owed
		task check_record(nak_rec_t got);
			nak_rec_t exp;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected record kind %0d", got.kind));
			end else begin
				exp = pending.pop_front();
				if (got.kind !== exp.kind)
					report_mismatch($sformatf("record_kind %0d, want %0d", got.kind, exp.kind));
				if (got.start_off !== exp.start_off)
					report_mismatch($sformatf("start_offset %h, want %h",
						got.start_off, exp.start_off));
				if (got.end_off !== exp.end_off)
					report_mismatch($sformatf("end_offset %h, want %h", got.end_off, exp.end_off));
				if (got.gap_idx !== exp.gap_idx)
					report_mismatch($sformatf("gap_index %0d, want %0d", got.gap_idx, exp.gap_idx));
				if (got.gaps !== exp.gaps)
					report_mismatch($sformatf("gaps_found %0d, want %0d", got.gaps, exp.gaps));
				if (got.consumed !== exp.consumed)
					report_mismatch($sformatf("bytes_consumed %0d, want %0d",
						got.consumed, exp.consumed));
				if (got.status !== exp.status)
					report_mismatch($sformatf("status %b, want %b", got.status, exp.status));
				if (got.last !== exp.last)
					report_mismatch($sformatf("last_of_run %b, want %b", got.last, exp.last));
			end
		endtask

		task check_leftovers();
			while (pending.size() != 0) begin
				report_mismatch($sformatf("record kind %0d never arrived", pending[0].kind));
				void'(pending.pop_front());
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	nak_decode_board board = new();
	int src_idle_pct = 37;
	int snk_idle_pct = 51;
	bit hold_go = 1'b0;

	nak_pdu_stream_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// One byte transfer on the slave side, with random idle cycles ahead of it
	task send_byte(logic [7:0] b, logic eop);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eop;
		do @(posedge clk); while (!s_axis_tready);
		board.note_byte(b, eop);
	endtask

	task send_pdu(pdu_bytes_t pdu);
		foreach (pdu[i])
			send_byte(pdu[i], i == pdu.size() - 1);
	endtask

	// Well-formed NAK: directive, scope pair, gap pairs, then a partial tail
	function pdu_bytes_t make_nak(int gaps, int tail);
		pdu_bytes_t q;
		q.push_back(NAK_DIRECTIVE);
		repeat (8 + 8 * gaps + tail)
			q.push_back(8'($urandom));
		return q;
	endfunction

	// Mostly well-formed PDUs, some bad directives and short ones
	function pdu_bytes_t make_random_pdu();
		pdu_bytes_t q;
		int pick;
		logic [7:0] b;
		pick = $urandom_range(99, 0);
		if (pick < 75) begin
			q = make_nak(($urandom_range(9, 0) == 0) ? $urandom_range(20, 14) : $urandom_range(4, 0),
				($urandom_range(3, 0) == 0) ? $urandom_range(7, 1) : 0);
		end else if (pick < 87) begin
			do b = 8'($urandom); while (b == NAK_DIRECTIVE);
			q.push_back(b);
			repeat ($urandom_range(40, 0))
				q.push_back(8'($urandom));
		end else begin
			q.push_back(NAK_DIRECTIVE);
			repeat ($urandom_range(7, 0))
				q.push_back(8'($urandom));
		end
		return q;
	endfunction

	task send_random(int nbytes);
		pdu_bytes_t q;
		int sent;
		sent = 0;
		while (sent < nbytes) begin
			q = make_random_pdu();
			send_pdu(q);
			sent += q.size();
		end
	endtask

	// Sender goes quiet until every owed record has been seen
	task wait_all_records();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// Master side: check each transfer, then pick the next tready
	initial begin
		nak_rec_t got;
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind      = record_kind_t'(m_axis_tuser);
				got.start_off = m_axis_tdata[31:0];
				got.end_off   = m_axis_tdata[63:32];
				got.gap_idx   = m_axis_tdata[67:64];
				got.gaps      = m_axis_tdata[72:68];
				got.consumed  = m_axis_tdata[80:73];
				got.status    = m_axis_tdata[81];
				got.last      = m_axis_tlast;
				board.check_record(got);
			end
			if (hold_go) begin
				hold_left = 300;
				hold_go = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		pdu_bytes_t q;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes: all-ones scope start, zero scope end, one gap ending with the PDU
		q = {NAK_DIRECTIVE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_pdu(q);
		// Wrong directive, single byte
		q = {8'hF7};
		send_pdu(q);
		// Too short: ends one byte before the scope pair completes
		q = make_nak(0, 0);
		void'(q.pop_back());
		send_pdu(q);

		send_random(330);
		wait_all_records();

		src_idle_pct = 51;
		snk_idle_pct = 37;
		send_random(330);
		wait_all_records();

		// No idling; long receiver hold while a PDU with too many gaps streams in
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_go = 1'b1;
		send_pdu(make_nak(18, 5));
		send_random(180);

		wait_all_records();
		repeat (20) @(posedge clk);
		board.check_leftovers();
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
